>>> rtl/core/ufs_pkg.sv
// Shared types, stencil weights and fixed-point constants for the face flux stencil.
package ufs_pkg;

  // Stencil taps at offsets -3 to +4
  localparam int N_TAPS = 8;

  // Q1.17 weights; +1.0 needs the nineteenth bit
  localparam int WGT_W  = 19;
  localparam int W_FRAC = 17;

  // Product of rounded sum and velocity sum carries 31 fraction bits, keep 16
  localparam int FLUX_SHIFT = 15;
  localparam int FLUX_W     = 32;

  // Register stages inside the weighted-sum unit
  localparam int WSUM_LATENCY = 3;

  localparam int ORDER_W = 3;

  typedef logic signed [WGT_W-1:0] weight_t;
  typedef logic [ORDER_W-1:0]      order_t;

  localparam order_t ORDER_RESET    = 3'd1;
  localparam order_t ORDER_BAD_ZERO = 3'd0;
  localparam order_t ORDER_BAD_SIX  = 3'd6;

  // Low-side weights per order, indexed by offset -3..+4; the high side is the mirror
  localparam weight_t LOW_SIDE_WEIGHTS [8][N_TAPS] = '{
    '{19'sd0, 19'sd0, 19'sd0, 19'sd0, 19'sd0, 19'sd0, 19'sd0, 19'sd0},
    '{19'sd0, 19'sd0, 19'sd0, 19'sd131072, 19'sd0, 19'sd0, 19'sd0, 19'sd0},
    '{19'sd0, 19'sd0, 19'sd0, 19'sd65536, 19'sd65536, 19'sd0, 19'sd0, 19'sd0},
    '{19'sd0, 19'sd0, -19'sd28041, 19'sd121617, 19'sd37495, 19'sd0, 19'sd0, 19'sd0},
    '{19'sd0, 19'sd0, -19'sd8192, 19'sd73728, 19'sd73728, -19'sd8192, 19'sd0, 19'sd0},
    '{19'sd0, 19'sd7268, -19'sd39996, 19'sd120069, 19'sd47385, -19'sd3654, 19'sd0, 19'sd0},
    '{19'sd0, 19'sd0, 19'sd0, 19'sd0, 19'sd0, 19'sd0, 19'sd0, 19'sd0},
    '{-19'sd2074, 19'sd14630, -19'sd48590, 19'sd122312, 19'sd49714, -19'sd5031, 19'sd110,
      19'sd0}
  };

  // Orders without a stencil
  function automatic logic is_bad_order(input order_t ord);
    return (ord == ORDER_BAD_ZERO) || (ord == ORDER_BAD_SIX);
  endfunction

endpackage

>>> rtl/core/ufs_wsum.sv
// Pipelined weighted sum of the stencil taps, rounded to 16 fraction bits.
module ufs_wsum #(
  parameter int PHI_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  ufs_pkg::weight_t                    weight_i [ufs_pkg::N_TAPS],
  input  logic signed [PHI_BITS-1:0]          phi_i    [ufs_pkg::N_TAPS],
  output logic                                valid_o,
  output logic signed [PHI_BITS+ufs_pkg::WGT_W+3-ufs_pkg::W_FRAC-1:0] sum_o
);

  localparam int PROD_W = PHI_BITS + ufs_pkg::WGT_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int SUM_W  = ACC_W - ufs_pkg::W_FRAC;
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1 << (ufs_pkg::W_FRAC - 1));

  logic                     v2_q, v3_q, v4_q;
  logic signed [PROD_W-1:0] prod_d [ufs_pkg::N_TAPS];
  logic signed [PROD_W-1:0] prod_q [ufs_pkg::N_TAPS];
  logic signed [ACC_W-1:0]  part_d [2];
  logic signed [ACC_W-1:0]  part_q [2];
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [SUM_W-1:0]  sum_d, sum_q;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v2_q <= valid_i;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Multiply each tap by its weight
  always_comb begin
    for (int i = 0; i < ufs_pkg::N_TAPS; i++) begin
      prod_d[i] = PROD_W'(phi_i[i]) * PROD_W'(weight_i[i]);
    end
  end

  // Reduce eight products to two partial sums
  always_comb begin
    for (int h = 0; h < 2; h++) begin
      part_d[h] = ACC_W'(prod_q[4*h])   + ACC_W'(prod_q[4*h+1])
                + ACC_W'(prod_q[4*h+2]) + ACC_W'(prod_q[4*h+3]);
    end
  end

  // Final add, round halves up and drop 17 fraction bits
  assign acc_rnd = part_q[0] + part_q[1] + ACC_HALF;
  assign sum_d   = acc_rnd[ACC_W-1:ufs_pkg::W_FRAC];

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    part_q <= part_d;
    sum_q  <= sum_d;
  end

  assign valid_o = v4_q;
  assign sum_o   = sum_q;

endmodule

>>> rtl/core/upwind_face_flux_stencil.sv
// Top level of the upwind-biased advective face flux stencil.
// One face is taken every cycle and its flux appears on face_flux_o with
// result_valid_o from the pipeline behind an accepted start: one stage picks
// the weights by order and velocity sign, three form the weighted sum (taps,
// two-level add, final add with rounding), one multiplies by the velocity sum
// and one rounds and saturates. The pipeline never stalls, so busy is always
// low and results are shown for one cycle only. Write scheme_order only when
// no request is in flight.
module upwind_face_flux_stencil #(
  parameter int PHI_BITS = 24,
  parameter int VEL_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Request channel
  input  logic                               start,
  output logic                               busy,
  input  logic signed [VEL_BITS-1:0]         vel_low_i,
  input  logic signed [VEL_BITS-1:0]         vel_high_i,
  input  logic signed [PHI_BITS-1:0]         phi_m3_i,
  input  logic signed [PHI_BITS-1:0]         phi_m2_i,
  input  logic signed [PHI_BITS-1:0]         phi_m1_i,
  input  logic signed [PHI_BITS-1:0]         phi_c0_i,
  input  logic signed [PHI_BITS-1:0]         phi_p1_i,
  input  logic signed [PHI_BITS-1:0]         phi_p2_i,
  input  logic signed [PHI_BITS-1:0]         phi_p3_i,
  input  logic signed [PHI_BITS-1:0]         phi_p4_i,
  // Result strobe
  output logic                               result_valid_o,
  output logic signed [ufs_pkg::FLUX_W-1:0]  face_flux_o,
  output logic                               bad_order_o,
  // Order register write
  input  logic                               order_we_i,
  input  ufs_pkg::order_t                    order_wdata_i
);

  localparam int V1_W   = VEL_BITS + 1;
  localparam int SUM_W  = PHI_BITS + ufs_pkg::WGT_W + 3 - ufs_pkg::W_FRAC;
  localparam int MUL_W  = SUM_W + V1_W;
  localparam int RND_W  = MUL_W - ufs_pkg::FLUX_SHIFT;
  localparam int CMP_W  = (RND_W > ufs_pkg::FLUX_W) ? RND_W : ufs_pkg::FLUX_W + 1;
  localparam int LAST   = ufs_pkg::WSUM_LATENCY - 1;
  localparam logic signed [MUL_W-1:0] MUL_HALF = MUL_W'(1 << (ufs_pkg::FLUX_SHIFT - 1));
  localparam logic signed [CMP_W-1:0] FLUX_MAX =
    {{(CMP_W-ufs_pkg::FLUX_W+1){1'b0}}, {(ufs_pkg::FLUX_W-1){1'b1}}};
  localparam logic signed [CMP_W-1:0] FLUX_MIN =
    {{(CMP_W-ufs_pkg::FLUX_W+1){1'b1}}, {(ufs_pkg::FLUX_W-1){1'b0}}};

  ufs_pkg::order_t                 order_q;
  logic                            accept;
  logic signed [V1_W-1:0]          vsum_d;
  logic                            neg_vel;
  logic signed [PHI_BITS-1:0]      phi_d  [ufs_pkg::N_TAPS];
  ufs_pkg::weight_t                w_d    [ufs_pkg::N_TAPS];

  logic                            v1_q;
  logic signed [V1_W-1:0]          vsum1_q;
  logic                            bad1_q;
  ufs_pkg::weight_t                w1_q   [ufs_pkg::N_TAPS];
  logic signed [PHI_BITS-1:0]      phi1_q [ufs_pkg::N_TAPS];

  logic signed [V1_W-1:0]          vsum_pipe_q [ufs_pkg::WSUM_LATENCY];
  logic                            bad_pipe_q  [ufs_pkg::WSUM_LATENCY];

  logic                            v4;
  logic signed [SUM_W-1:0]         sum4;

  logic                            v5_q;
  logic                            bad5_q;
  logic signed [MUL_W-1:0]         mul5_q;

  logic signed [MUL_W-1:0]         mul_rnd;
  logic signed [RND_W-1:0]         flux_rnd;
  logic signed [CMP_W-1:0]         flux_ext;
  logic signed [ufs_pkg::FLUX_W-1:0] flux_d;

  logic                            v6_q;
  logic                            bad6_q;
  logic signed [ufs_pkg::FLUX_W-1:0] flux6_q;

  // Nothing downstream can hold results off, so requests are never refused
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Hold the scheme order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ufs_pkg::ORDER_RESET;
    end else if (order_we_i) begin
      order_q <= order_wdata_i;
    end
  end

  // Face velocity and stencil side; mirror the weights for negative velocity
  assign vsum_d  = V1_W'(vel_low_i) + V1_W'(vel_high_i);
  assign neg_vel = vsum_d[V1_W-1];

  always_comb begin
    phi_d[0] = phi_m3_i;
    phi_d[1] = phi_m2_i;
    phi_d[2] = phi_m1_i;
    phi_d[3] = phi_c0_i;
    phi_d[4] = phi_p1_i;
    phi_d[5] = phi_p2_i;
    phi_d[6] = phi_p3_i;
    phi_d[7] = phi_p4_i;
    for (int i = 0; i < ufs_pkg::N_TAPS; i++) begin
      w_d[i] = neg_vel ? ufs_pkg::LOW_SIDE_WEIGHTS[order_q][ufs_pkg::N_TAPS-1-i]
                       : ufs_pkg::LOW_SIDE_WEIGHTS[order_q][i];
    end
  end

  // Valid bits of the stages around the sum unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v5_q <= v4;
      v6_q <= v5_q;
    end
  end

  // Capture the request with its weights
  always_ff @(posedge clk_i) begin
    vsum1_q <= vsum_d;
    bad1_q  <= ufs_pkg::is_bad_order(order_q);
    w1_q    <= w_d;
    phi1_q  <= phi_d;
  end

  ufs_wsum #(
    .PHI_BITS (PHI_BITS)
  ) u_wsum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v1_q),
    .weight_i (w1_q),
    .phi_i    (phi1_q),
    .valid_o  (v4),
    .sum_o    (sum4)
  );

  // Carry velocity sum and order flag alongside the sum unit
  always_ff @(posedge clk_i) begin
    vsum_pipe_q[0] <= vsum1_q;
    bad_pipe_q[0]  <= bad1_q;
    for (int k = 1; k < ufs_pkg::WSUM_LATENCY; k++) begin
      vsum_pipe_q[k] <= vsum_pipe_q[k-1];
      bad_pipe_q[k]  <= bad_pipe_q[k-1];
    end
  end

  // Scale the rounded sum by the velocity sum
  always_ff @(posedge clk_i) begin
    mul5_q <= MUL_W'(sum4) * MUL_W'(vsum_pipe_q[LAST]);
    bad5_q <= bad_pipe_q[LAST];
  end

  // Round halves up to 16 fraction bits and saturate; zero on a bad order
  assign mul_rnd  = mul5_q + MUL_HALF;
  assign flux_rnd = mul_rnd[MUL_W-1:ufs_pkg::FLUX_SHIFT];
  assign flux_ext = CMP_W'(flux_rnd);

  always_comb begin
    if (bad5_q) begin
      flux_d = '0;
    end else if (flux_ext > FLUX_MAX) begin
      flux_d = FLUX_MAX[ufs_pkg::FLUX_W-1:0];
    end else if (flux_ext < FLUX_MIN) begin
      flux_d = FLUX_MIN[ufs_pkg::FLUX_W-1:0];
    end else begin
      flux_d = flux_ext[ufs_pkg::FLUX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    flux6_q <= flux_d;
    bad6_q  <= bad5_q;
  end

  assign result_valid_o = v6_q;
  assign face_flux_o    = flux6_q;
  assign bad_order_o    = bad6_q;

endmodule

>>> rtl/core/ufs_checker.sv
// Port-level checks on the face flux stencil, bound to the top level.
module ufs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              result_valid_o,
  input logic signed [ufs_pkg::FLUX_W-1:0] face_flux_o,
  input logic                              bad_order_o
);

  // The pipeline never refuses a request
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised on a pipeline that cannot stall");

  // Every result traces back to a matching earlier request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, 6))
    else $error("result without a matching request");

  // A request accepted out of reset yields its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni, 1) && $past(rst_ni, 2) && $past(rst_ni, 3) && $past(rst_ni, 4) &&
     $past(rst_ni, 5) && $past(rst_ni, 6) && $past(start, 6)) |-> result_valid_o)
    else $error("request lost in the pipeline");

  // An unsupported order gives zero flux
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && bad_order_o) |-> (face_flux_o == '0))
    else $error("non-zero flux with a bad order");

endmodule

bind upwind_face_flux_stencil ufs_checker u_ufs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .face_flux_o    (face_flux_o),
  .bad_order_o    (bad_order_o)
);
